/* hw/rtl/itrd_pkg.sv */
// ----------------------------------------------------------------------------
// itrd_pkg: shared types and constants for the integer to radix digits block
// Holds character codes, radix limits, the job control struct and the digit
// to ASCII mapping used by the back end.
// ----------------------------------------------------------------------------
package itrd_pkg;

    localparam int RADIX_W  = 5;
    localparam int DIGIT_W  = 4;
    localparam int CHAR_W   = 7;
    // quotient bits resolved per divider cycle
    localparam int DIV_STEP = 8;

    localparam logic [RADIX_W-1:0] RADIX_RESET   = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN     = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX     = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_DECIMAL = 5'd10;

    localparam logic [CHAR_W-1:0]  CH_ZERO     = 7'd48;
    localparam logic [CHAR_W-1:0]  CH_LETTER_A = 7'd97;
    localparam logic [CHAR_W-1:0]  CH_MINUS    = 7'd45;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 4'd10;

    // per-job control carried alongside the magnitude
    typedef struct packed {
        logic               minus;
        logic [RADIX_W-1:0] base;
    } t_job_ctl;

    // digit 0..15 to ASCII, lower-case letters above nine
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d >= DIGIT_TEN) begin
            c = CH_LETTER_A + CHAR_W'(d - DIGIT_TEN);
        end else begin
            c = CH_ZERO + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

/* hw/rtl/itrd_ram.sv */
// ----------------------------------------------------------------------------
// itrd_ram: generic single-write, single-read RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module itrd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/itrd_front.sv */
// ----------------------------------------------------------------------------
// itrd_front: input side of the converter
// Holds the radix register, turns each accepted word into a magnitude plus
// sign/radix control, and buffers jobs in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module itrd_front #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [itrd_pkg::RADIX_W-1:0]         i_cfg_data,
    input  logic                                 i_push,
    input  logic signed [VALUE_WIDTH-1:0]        i_value,
    output logic                                 o_full,
    output logic                                 o_job_valid,
    input  logic                                 i_job_ready,
    output logic [VALUE_WIDTH-1:0]               o_job_mag,
    output itrd_pkg::t_job_ctl                   o_job_ctl
);

    logic [itrd_pkg::RADIX_W-1:0] r_radix;
    logic [itrd_pkg::RADIX_W-1:0] eff_radix;
    logic                         negative;
    logic [VALUE_WIDTH-1:0]       mag;
    itrd_pkg::t_job_ctl           ctl;

    logic [VALUE_WIDTH-1:0] r_mag [2];
    itrd_pkg::t_job_ctl     r_ctl [2];
    logic                   r_wptr;
    logic                   r_rptr;
    logic [1:0]             r_count;
    logic                   do_push;
    logic                   do_pop;

    // radix register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= itrd_pkg::RADIX_RESET;
        end else if (i_cfg_we) begin
            r_radix <= i_cfg_data;
        end
    end

    // clamp radix and classify the word
    always_comb begin
        if (r_radix < itrd_pkg::RADIX_MIN) begin
            eff_radix = itrd_pkg::RADIX_MIN;
        end else if (r_radix > itrd_pkg::RADIX_MAX) begin
            eff_radix = itrd_pkg::RADIX_MAX;
        end else begin
            eff_radix = r_radix;
        end
        negative  = i_value[VALUE_WIDTH-1];
        // most negative value wraps to 2^(W-1) as unsigned, which is right
        mag       = negative ? (~i_value + 1'b1) : i_value;
        ctl.minus = negative && (eff_radix == itrd_pkg::RADIX_DECIMAL);
        ctl.base  = eff_radix;
    end

    // two-entry job queue
    assign o_full   = (r_count == 2'd2);
    assign do_push  = i_push && !o_full;
    assign do_pop   = o_job_valid && i_job_ready;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mag[r_wptr] <= mag;
            r_ctl[r_wptr] <= ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    assign o_job_valid = (r_count != 2'd0);
    assign o_job_mag   = r_mag[r_rptr];
    assign o_job_ctl   = r_ctl[r_rptr];

endmodule

/* hw/rtl/itrd_back.sv */
// ----------------------------------------------------------------------------
// itrd_back: digit generation and character output
// Divides the magnitude by the radix one digit at a time (DIV_STEP quotient
// bits a cycle), stores digits least significant first, then replays them
// most significant first through a one-word output register.
// ----------------------------------------------------------------------------
module itrd_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    output logic                          o_job_ready,
    input  logic [VALUE_WIDTH-1:0]        i_job_mag,
    input  itrd_pkg::t_job_ctl            i_job_ctl,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [itrd_pkg::CHAR_W-1:0]   o_char_code,
    output logic                          o_last_char
);

    localparam int STEP   = itrd_pkg::DIV_STEP;
    localparam int NCH    = (VALUE_WIDTH + STEP - 1) / STEP;
    localparam int PAD_W  = NCH * STEP;
    localparam int CHK_W  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int ADDR_W = $clog2(VALUE_WIDTH);
    localparam logic [CHK_W-1:0] CHK_LAST = CHK_W'(NCH - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SIGN = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_WR   = 3'd4;

    logic [2:0]                    r_state, n_state;
    logic [PAD_W-1:0]              r_work, n_work;
    logic [itrd_pkg::DIGIT_W-1:0]  r_rem, n_rem;
    logic [CHK_W-1:0]              r_chunk, n_chunk;
    logic [ADDR_W-1:0]             r_idx, n_idx;
    logic                          r_minus, n_minus;
    logic [itrd_pkg::RADIX_W-1:0]  r_base, n_base;
    logic                          r_out_valid, n_out_valid;
    logic [itrd_pkg::CHAR_W-1:0]   r_out_char, n_out_char;
    logic                          r_out_last, n_out_last;

    logic [STEP-1:0]               q_bits;
    logic [itrd_pkg::DIGIT_W-1:0]  step_rem;
    logic [PAD_W-1:0]              step_work;
    logic                          out_free;
    logic                          ram_we;
    logic                          ram_re;
    logic [itrd_pkg::DIGIT_W-1:0]  ram_rdata;

    // one divider cycle: STEP restoring steps on a 5-bit partial remainder
    always_comb begin
        logic [itrd_pkg::RADIX_W-1:0] t5;
        logic [itrd_pkg::DIGIT_W-1:0] t_rem;
        t_rem  = r_rem;
        q_bits = '0;
        for (int i = 0; i < STEP; i++) begin
            t5 = {t_rem, r_work[PAD_W-1-i]};
            if (t5 >= r_base) begin
                q_bits[STEP-1-i] = 1'b1;
                t5 = t5 - r_base;
            end
            t_rem = t5[itrd_pkg::DIGIT_W-1:0];
        end
        step_rem  = t_rem;
        step_work = (r_work << STEP) | PAD_W'(q_bits);
    end

    assign out_free = !r_out_valid || i_pop;
    assign ram_we   = (r_state == S_DIV) && (r_chunk == CHK_LAST);
    assign ram_re   = (r_state == S_RD);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_work      = r_work;
        n_rem       = r_rem;
        n_chunk     = r_chunk;
        n_idx       = r_idx;
        n_minus     = r_minus;
        n_base      = r_base;
        n_out_valid = r_out_valid && !i_pop;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        o_job_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_job_ready = 1'b1;
                if (i_job_valid) begin
                    n_work  = PAD_W'(i_job_mag);
                    n_minus = i_job_ctl.minus;
                    n_base  = i_job_ctl.base;
                    n_rem   = '0;
                    n_chunk = '0;
                    n_idx   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_work = step_work;
                n_rem  = step_rem;
                if (r_chunk == CHK_LAST) begin
                    // digit done, written to RAM this cycle
                    n_rem   = '0;
                    n_chunk = '0;
                    if (step_work == '0) begin
                        n_state = r_minus ? S_SIGN : S_RD;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    n_chunk = r_chunk + 1'b1;
                end
            end
            S_SIGN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = itrd_pkg::CH_MINUS;
                    n_out_last  = 1'b0;
                    n_state     = S_RD;
                end
            end
            S_RD: begin
                n_state = S_WR;
            end
            S_WR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = itrd_pkg::digit_char(ram_rdata);
                    n_out_last  = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_chunk     <= '0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_chunk     <= n_chunk;
            r_idx       <= n_idx;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_work     <= n_work;
        r_rem      <= n_rem;
        r_minus    <= n_minus;
        r_base     <= n_base;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    // digit store
    itrd_ram #(
        .WIDTH (itrd_pkg::DIGIT_W),
        .DEPTH (VALUE_WIDTH)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (step_rem),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign o_empty     = !r_out_valid;
    assign o_char_code = r_out_char;
    assign o_last_char = r_out_last;

endmodule

/* hw/rtl/integer_to_radix_digits.sv */
// ----------------------------------------------------------------------------
// integer_to_radix_digits: signed integer to ASCII text in radix 2 to 16
// Queue-style ports on both sides, one radix register, one character per
// output word with a flag on the final character.
// ----------------------------------------------------------------------------
// Each pushed word is converted to ASCII digits, most significant first,
// lower-case a-f above nine, a single '0' for zero, and a leading '-' only
// for negative values in radix 10; last_char marks the final character. The
// radix register (reset 10) clamps values below 2 to 2 and above 16 to 16
// and should be written only while no conversion is in flight. The front end
// buffers up to two words while the back end works. The back end divides by
// the radix at 8 quotient bits per cycle, one digit at a time, and each
// character is then read back through the digit RAM's registered read
// (S_RD, then S_WR, which waits until the output word is free).
// ----------------------------------------------------------------------------
module integer_to_radix_digits #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [itrd_pkg::RADIX_W-1:0]       i_cfg_data,
    input  logic                               i_push,
    input  logic signed [VALUE_WIDTH-1:0]      i_value,
    output logic                               o_full,
    output logic                               o_empty,
    input  logic                               i_pop,
    output logic [itrd_pkg::CHAR_W-1:0]        o_char_code,
    output logic                               o_last_char
);

    logic                   job_valid;
    logic                   job_ready;
    logic [VALUE_WIDTH-1:0] job_mag;
    itrd_pkg::t_job_ctl     job_ctl;

    itrd_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_push      (i_push),
        .i_value     (i_value),
        .o_full      (o_full),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job_mag   (job_mag),
        .o_job_ctl   (job_ctl)
    );

    itrd_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job_mag   (job_mag),
        .i_job_ctl   (job_ctl),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

endmodule
